// ----- rtl/lfsm_pkg.sv -----
// Shared types and constants for the largest free square map.
package lfsm_pkg;

	localparam int CoordW = 6;
	localparam int CodeW  = 8;
	localparam int SizeW  = 6;
	localparam int CfgW   = 6;

	localparam logic [SizeW-1:0] SizeCap       = 6'd63;
	localparam logic [CfgW-1:0]  GridWidthRst  = 6'd62;
	localparam logic [CfgW-1:0]  GridHeightRst = 6'd62;

	typedef enum logic [0:0] {
		CFG_GRID_WIDTH  = 1'b0,
		CFG_GRID_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		logic load;
		logic wr_commit;
		logic q_init;
		logic q_step;
		logic res_bad;
		logic out_load;
	} lfsm_cmd_t;

	typedef struct packed {
		logic query;
		logic bad;
		logic stop;
		logic out_free;
	} lfsm_sts_t;

endpackage

// ----- rtl/lfsm_if.sv -----
// Request and response channel interfaces.
interface lfsm_req_if;
	import lfsm_pkg::*;
	logic              valid;
	logic              ready;
	logic [0:0]        operation;
	logic [CoordW-1:0] pos_x;
	logic [CoordW-1:0] pos_y;
	logic [CodeW-1:0]  tile_code;
	modport source (output valid, operation, pos_x, pos_y, tile_code, input ready);
	modport sink (input valid, operation, pos_x, pos_y, tile_code, output ready);
endinterface

interface lfsm_rsp_if;
	import lfsm_pkg::*;
	logic             valid;
	logic             ready;
	logic [SizeW-1:0] square_size;
	logic             bad_query;
	modport source (output valid, square_size, bad_query, input ready);
	modport sink (input valid, square_size, bad_query, output ready);
endinterface

// ----- rtl/lfsm_ram.sv -----
// Generic single-port-write RAM with registered read.
module lfsm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/lfsm_ctrl.sv -----
// Sequencer for tile writes and square queries.
module lfsm_ctrl import lfsm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  lfsm_sts_t sts,
	output lfsm_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_WR_RD   = 6'b000010,
		S_WR_WB   = 6'b000100,
		S_Q_START = 6'b001000,
		S_SCAN    = 6'b010000,
		S_RESULT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					if (!sts.query) begin
						state_d = S_WR_RD;
					end else if (sts.bad) begin
						cmd.res_bad = 1'b1;
						state_d     = S_RESULT;
					end else begin
						state_d = S_Q_START;
					end
				end
			end
			S_WR_RD: begin
				state_d = S_WR_WB;
			end
			S_WR_WB: begin
				cmd.wr_commit = 1'b1;
				state_d       = S_IDLE;
			end
			S_Q_START: begin
				cmd.q_init = 1'b1;
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				cmd.q_step = 1'b1;
				if (sts.stop) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/lfsm_dp.sv -----
// Datapath: tile store, row scan window and result registers.
module lfsm_dp import lfsm_pkg::*; #(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [CfgW-1:0]   cfg_wdata,
	input  logic [0:0]        operation,
	input  logic [CoordW-1:0] pos_x,
	input  logic [CoordW-1:0] pos_y,
	input  logic [CodeW-1:0]  tile_code,
	input  logic              rsp_ready,
	input  lfsm_cmd_t         cmd,
	output lfsm_sts_t         sts,
	output logic              rsp_valid,
	output logic [SizeW-1:0]  square_size,
	output logic              bad_query
);

	localparam int RAW = $clog2(GRID_ROWS);
	localparam int CAW = $clog2(GRID_COLS);
	localparam int RW  = (RAW + 1 > 7) ? RAW + 1 : 7;
	localparam int CW  = (CAW + 1 > 7) ? CAW + 1 : 7;
	localparam int LW  = SizeW + 1;

	logic [CfgW-1:0]      gw_q, gh_q;
	logic [CoordW-1:0]    x_q, y_q;
	logic                 blk_q;
	logic [RW-1:0]        row_q;
	logic [LW-1:0]        len_q;
	logic [GRID_COLS-1:0] acc_q, mask_q;
	logic                 rd_ok_s1;
	logic [GRID_ROWS-1:0] row_valid_q;
	logic [SizeW-1:0]     res_size_q, out_size_q;
	logic                 res_bad_q, out_bad_q, out_valid_q;

	logic [RW-1:0]        rd_row, y_ext;
	logic                 rd_in, wr_in, we;
	logic [RAW-1:0]       rd_addr, wr_addr;
	logic [GRID_COLS-1:0] rdata, row_eff, wdata, acc_new, mask_new;
	logic [CW-1:0]        col, x_ext;
	logic                 col_oob, row_oob, hit, sat, stop;
	logic [LW-1:0]        klen;

	assign y_ext   = RW'(y_q);
	assign x_ext   = CW'(x_q);
	assign rd_row  = cmd.q_step ? row_q + RW'(1) : y_ext;
	assign rd_in   = rd_row < RW'(GRID_ROWS);
	assign rd_addr = rd_row[RAW-1:0];
	assign wr_in   = (x_ext < CW'(GRID_COLS)) && (y_ext < RW'(GRID_ROWS));
	assign wr_addr = y_ext[RAW-1:0];
	assign we      = cmd.wr_commit && wr_in;
	assign row_eff = rd_ok_s1 ? rdata : '0;

	always_comb begin
		for (int i = 0; i < GRID_COLS; i++) begin
			wdata[i]    = (x_ext == CW'(i)) ? blk_q : row_eff[i];
			mask_new[i] = mask_q[i] | (col == CW'(i));
		end
	end

	lfsm_ram #(
		.WIDTH(GRID_COLS),
		.DEPTH(GRID_ROWS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(wr_addr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// one step checks new right column and new bottom row together
	assign col     = x_ext + CW'(len_q) - CW'(1);
	assign col_oob = (col > CW'(gw_q) + CW'(1)) || (col >= CW'(GRID_COLS));
	assign row_oob = (row_q > RW'(gh_q) + RW'(1)) || (row_q >= RW'(GRID_ROWS));
	assign acc_new = acc_q | row_eff;
	assign hit     = |(acc_new & mask_new);
	assign sat     = len_q == LW'(SizeCap) + LW'(1);
	assign stop    = sat || col_oob || row_oob || hit;
	assign klen    = len_q - LW'(1);

	assign sts.query    = operation == OP_QUERY;
	assign sts.bad      = (pos_x == '0) || (pos_y == '0) || (pos_x > gw_q) || (pos_y > gh_q);
	assign sts.stop     = stop;
	assign sts.out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q        <= GridWidthRst;
			gh_q        <= GridHeightRst;
			row_valid_q <= '0;
			rd_ok_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_GRID_WIDTH:  gw_q <= cfg_wdata;
					CFG_GRID_HEIGHT: gh_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (we) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			rd_ok_s1 <= rd_in ? row_valid_q[rd_addr] : 1'b0;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= pos_x;
			y_q   <= pos_y;
			blk_q <= |tile_code;
		end
		if (cmd.q_init) begin
			row_q  <= y_ext;
			len_q  <= LW'(1);
			acc_q  <= '0;
			mask_q <= '0;
		end else if (cmd.q_step && !stop) begin
			row_q  <= row_q + RW'(1);
			len_q  <= len_q + LW'(1);
			acc_q  <= acc_new;
			mask_q <= mask_new;
		end
		if (cmd.res_bad) begin
			res_size_q <= '0;
			res_bad_q  <= 1'b1;
		end else if (cmd.q_step && stop) begin
			res_size_q <= klen[SizeW-1:0];
			res_bad_q  <= 1'b0;
		end
		if (cmd.out_load) begin
			out_size_q <= res_size_q;
			out_bad_q  <= res_bad_q;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign square_size = out_size_q;
	assign bad_query   = out_bad_q;

endmodule

// ----- rtl/largest_free_square_map.sv -----
// Largest free square map: top level.
// Tile write: after acceptance a read state and a write-back state pass before the next item can be accepted.
// Query: after acceptance a start state, then a scan of one store row per cycle, then the result state.
// Bad query: goes straight from idle to the result state, with no scan. Items are handled one at a time.
// Reset clears the row valid bits, so the whole store reads free at once.
// Reset sets grid_width and grid_height to 62.
module largest_free_square_map import lfsm_pkg::*; #(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [0:0]      cfg_index,
	input  logic [CfgW-1:0] cfg_wdata,
	lfsm_req_if.sink        req,
	lfsm_rsp_if.source      rsp
);

	lfsm_cmd_t cmd;
	lfsm_sts_t sts;

	lfsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfsm_dp #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.operation  (req.operation),
		.pos_x      (req.pos_x),
		.pos_y      (req.pos_y),
		.tile_code  (req.tile_code),
		.rsp_ready  (rsp.ready),
		.cmd        (cmd),
		.sts        (sts),
		.rsp_valid  (rsp.valid),
		.square_size(rsp.square_size),
		.bad_query  (rsp.bad_query)
	);

`ifndef SYNTHESIS
	a_bad_size_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.bad_query |-> rsp.square_size == '0)
		else $error("bad query with nonzero size");

	a_write_timing: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.operation == OP_WRITE |=>
		!req.ready ##1 !req.ready ##1 req.ready)
		else $error("tile write did not finish in three cycles");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.operation == OP_QUERY |=> !req.ready)
		else $error("ready while query in progress");

	a_scan_no_result_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rsp.valid && !cmd.out_load)
		else $error("result loaded twice");
`endif

endmodule
